@@ sv/sobel_magnitude_minmax_normalize_defines.svh @@
// assertion macros shared by the checker
`ifndef SOBEL_MAGNITUDE_MINMAX_NORMALIZE_DEFINES_SVH
`define SOBEL_MAGNITUDE_MINMAX_NORMALIZE_DEFINES_SVH

// implication checked at every rising clock edge, disabled in reset
`define SMN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/smn_pkg.sv @@
package smn_pkg;
  localparam int unsigned DefMaxWidth    = 512;
  localparam int unsigned DefMaxHeight   = 256;
  localparam int unsigned DefMagFracBits = 4;
  localparam int unsigned MagW           = 15;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned CfgDataW       = 10;
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdFetch = 1'b1;
endpackage

@@ sv/sobel_magnitude_minmax_normalize.sv @@
// a load with a full window passes StLdRd, StLdWin, StLdSq, StLdSum, an iterative square root
//   of one result bit a cycle (11 + MAG_FRAC_BITS steps) and StLdFin before the next item is taken
// a load outside a full window passes StLdRd, StLdWin and StLdFin, a load during readout is
//   dropped in the accept cycle; a fetch passes StFtRd, StFtSub, a preload step and a restoring
//   divider of 8 quotient bits, one bit a cycle, then StOut; it skips the divider when max equals
//   min and goes straight to StOut when not ready; the result then sits in an output register
//   until taken; one item at a time, the square root or the divider sets the pace
// reset: rst_ni asynchronous, active low; clears control, window and min/max, no memory sweep
module sobel_magnitude_minmax_normalize
  import smn_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT    = DefMaxHeight,
  parameter int unsigned MAG_FRAC_BITS = DefMagFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // pixel [7:0]
  input  logic                s_axis_tuser_i,   // cmd
  // output stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,   // out_pixel [7:0]
  output logic                m_axis_tuser_o,   // status
  output logic                m_axis_tlast_o    // last_pixel
);
  localparam int unsigned ColW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RowW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LineD  = 2 * MAX_WIDTH;
  localparam int unsigned LineAw = $clog2(LineD);
  localparam int unsigned MagD   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned MagAw  = $clog2(MagD);
  localparam int unsigned IdxW   = $clog2(MagD + 1);
  localparam int unsigned GW     = 12;              // |g| <= 1020 fits 11 bits, sign
  localparam int unsigned SqW    = 21 + 2 * MAG_FRAC_BITS;
  localparam int unsigned RootW  = (SqW + 1) / 2;
  localparam int unsigned RootIt = RootW;
  localparam int unsigned ItW    = $clog2(RootIt + 1);
  localparam logic [MagW-1:0] MagMax = '1;

  // states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLdRd  = 4'd1;
  localparam logic [3:0] StLdWin = 4'd2;
  localparam logic [3:0] StLdSq  = 4'd3;
  localparam logic [3:0] StLdSum = 4'd4;
  localparam logic [3:0] StSqrt  = 4'd5;
  localparam logic [3:0] StLdFin = 4'd6;
  localparam logic [3:0] StFtRd  = 4'd7;
  localparam logic [3:0] StFtSub = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  localparam logic PhLoad = 1'b0;
  localparam logic PhRead = 1'b1;

  logic [3:0]      state_q, state_d;
  logic            phase_q;
  logic [9:0]      width_q;
  logic [8:0]      height_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [IdxW-1:0] ridx_q;
  logic [MagW-1:0] min_q, max_q;
  logic [7:0]      win_q [6];
  logic [7:0]      pix_q;

  // clamped frame size
  logic [ColW-1:0] w_use;
  logic [RowW-1:0] h_use;
  always_comb begin
    if (width_q < 10'd3) w_use = ColW'(3);
    else if ({{(ColW > 10 ? ColW - 10 : 0){1'b0}}, width_q} > ColW'(MAX_WIDTH))
      w_use = ColW'(MAX_WIDTH);
    else w_use = ColW'(width_q);
    if (height_q < 9'd3) h_use = RowW'(3);
    else if ({{(RowW > 9 ? RowW - 9 : 0){1'b0}}, height_q} > RowW'(MAX_HEIGHT))
      h_use = RowW'(MAX_HEIGHT);
    else h_use = RowW'(height_q);
  end

  // line store: two rows, top row slot by row parity
  logic              col_ok;
  logic [LineAw-1:0] top_slot, mid_slot, line_raddr;
  logic              line_we;
  logic [7:0]        line_rdata;
  assign col_ok   = col_q < ColW'(MAX_WIDTH);
  assign top_slot = LineAw'(row_q[0] ? MAX_WIDTH : 0)
                  + LineAw'(col_ok ? col_q : '0);
  assign mid_slot = LineAw'(row_q[0] ? 0 : MAX_WIDTH)
                  + LineAw'(col_ok ? col_q : '0);
  // top read issued in the accept cycle, mid read issued in StLdRd
  logic [7:0] top_pix_q;
  logic       rd_mid_q;

  smn_ram #(.Width(8), .Depth(LineD)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (top_slot),
    .wdata_i (pix_q),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // magnitude store
  logic             mag_we;
  logic [MagAw-1:0] mag_waddr, mag_raddr;
  logic [MagW-1:0]  mag_wdata, mag_rdata;
  logic [IdxW-1:0]  widx_q;

  smn_ram #(.Width(MagW), .Depth(MagD)) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (mag_we),
    .waddr_i (mag_waddr),
    .wdata_i (mag_wdata),
    .raddr_i (mag_raddr),
    .rdata_o (mag_rdata)
  );

  // datapath registers
  logic signed [GW-1:0] gx_q, gy_q;
  logic [21:0]          sq_a_q, sq_b_q;
  logic [2*RootW-1:0]   rem_q;
  logic [RootW-1:0]     root_q;
  logic [ItW-1:0]       it_q;
  logic [MagW-1:0]      drange_q;
  logic [MagW+8-1:0]    dvd_q;
  logic [MagW:0]        drem_q;
  logic [7:0]           quo_q;
  logic [3:0]           dit_q;
  logic                 last_q;
  logic [7:0]           out_pix_q;
  logic                 out_stat_q, out_last_q, out_vld_q;

  // window of the current item
  logic [7:0] a00, a10, a20, a01, a21, a02, a12, a22;
  assign a00 = win_q[0];
  assign a10 = win_q[1];
  assign a20 = win_q[2];
  assign a01 = win_q[3];
  assign a21 = win_q[5];
  assign a02 = top_pix_q;
  assign a12 = line_rdata;
  assign a22 = pix_q;

  logic signed [GW-1:0] gx_c, gy_c;
  logic [10:0]          ax, ay;
  assign gx_c = (GW'(a02) + (GW'(a12) <<< 1) + GW'(a22))
              - (GW'(a00) + (GW'(a10) <<< 1) + GW'(a20));
  assign gy_c = (GW'(a00) + (GW'(a01) <<< 1) + GW'(a02))
              - (GW'(a20) + (GW'(a21) <<< 1) + GW'(a22));
  assign ax = gx_q[GW-1] ? 11'(-gx_q) : 11'(gx_q);
  assign ay = gy_q[GW-1] ? 11'(-gy_q) : 11'(gy_q);

  // restoring square root, one result bit a cycle, radicand bit pairs from the top
  logic [2*RootW-1:0] sq_full;
  assign sq_full = (2*RootW)'((sq_a_q + sq_b_q)) << (2 * MAG_FRAC_BITS);
  logic [2*RootW+1:0] srem_q;
  logic [2*RootW+1:0] s_cand, s_try;
  assign s_cand = {srem_q[2*RootW-1:0], rem_q[2*RootW-1 -: 2]};
  assign s_try  = s_cand - {root_q, 2'b01};

  logic win_valid;
  assign win_valid = (row_q >= RowW'(2)) && (col_q >= ColW'(2));

  logic [MagW-1:0] mag_sat;
  assign mag_sat = (root_q > RootW'(MagMax)) ? MagMax : MagW'(root_q);

  // divider: 255*d / range, restoring, one bit a cycle
  logic [MagW:0] dtry;
  assign dtry = {drem_q[MagW-1:0], dvd_q[MagW+7]} - {1'b0, drange_q};

  logic [IdxW-1:0] total;
  assign total = IdxW'((w_use - ColW'(2))) * IdxW'((h_use - RowW'(2)));

  // handshake
  logic in_acc;
  assign s_axis_tready_o = (state_q == StIdle) && !out_vld_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign line_we    = (state_q == StLdWin);
  assign line_raddr = rd_mid_q ? mid_slot : top_slot;
  assign mag_we     = (state_q == StLdFin) && win_valid && (widx_q < IdxW'(MagD));
  assign mag_waddr  = MagAw'(widx_q);
  assign mag_wdata  = mag_sat;
  assign mag_raddr  = MagAw'(ridx_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CmdLoad) state_d = (phase_q == PhLoad) ? StLdRd : StIdle;
          else if (phase_q == PhRead) state_d = StFtRd;
          else state_d = StOut;
        end
      end
      StLdRd:  state_d = StLdWin;
      StLdWin: state_d = win_valid ? StLdSq : StLdFin;
      StLdSq:  state_d = StLdSum;
      StLdSum: state_d = StSqrt;
      StSqrt:  state_d = (it_q == ItW'(RootIt - 1)) ? StLdFin : StSqrt;
      StLdFin: state_d = StIdle;
      StFtRd:  state_d = StFtSub;
      StFtSub: state_d = (max_q > min_q) ? StDiv : StOut;
      StDiv:   state_d = (dit_q == 4'd8) ? StOut : StDiv;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic [MagW-1:0] dcl;
  always_comb begin
    dcl = (mag_rdata > min_q) ? mag_rdata - min_q : '0;
    if (dcl > max_q - min_q) dcl = max_q - min_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      phase_q    <= PhLoad;
      width_q    <= 10'd275;
      height_q   <= 9'd183;
      col_q      <= '0;
      row_q      <= '0;
      ridx_q     <= '0;
      min_q      <= MagMax;
      max_q      <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
      out_vld_q  <= 1'b0;
      rd_mid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegWidth) width_q <= cfg_data_i;
        else if (cfg_index_i == RegHeight) height_q <= cfg_data_i[8:0];
      end
      if (m_axis_tvalid_o && m_axis_tready_i) out_vld_q <= 1'b0;
      rd_mid_q <= (state_q == StIdle) && in_acc;
      unique case (state_q)
        StLdWin: begin
          for (int k = 0; k < 3; k++) win_q[k] <= win_q[3 + k];
          win_q[3] <= top_pix_q;
          win_q[4] <= line_rdata;
          win_q[5] <= pix_q;
        end
        StLdFin: begin
          if (win_valid) begin
            if (mag_sat < min_q) min_q <= mag_sat;
            if (mag_sat > max_q) max_q <= mag_sat;
          end
          if (col_q + ColW'(1) >= w_use) begin
            col_q <= '0;
            if (row_q + RowW'(1) >= h_use) begin
              row_q   <= '0;
              ridx_q  <= '0;
              phase_q <= PhRead;
            end else begin
              row_q <= row_q + RowW'(1);
            end
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end
        StOut: begin
          out_vld_q <= 1'b1;
          if (phase_q == PhRead) begin
            if (last_q) begin
              for (int i = 0; i < 6; i++) win_q[i] <= '0;
              min_q   <= MagMax;
              max_q   <= '0;
              col_q   <= '0;
              row_q   <= '0;
              ridx_q  <= '0;
              phase_q <= PhLoad;
            end else begin
              ridx_q <= ridx_q + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) pix_q <= s_axis_tdata_i;
    if (state_q == StLdRd) top_pix_q <= line_rdata;
    if (state_q == StLdWin) begin
      gx_q   <= gx_c;
      gy_q   <= gy_c;
      widx_q <= IdxW'(row_q - RowW'(2)) * IdxW'(w_use - ColW'(2)) + IdxW'(col_q - ColW'(2));
    end
    if (state_q == StLdSq) begin
      sq_a_q <= 22'(ax) * 22'(ax);
      sq_b_q <= 22'(ay) * 22'(ay);
    end
    if (state_q == StLdSum) begin
      rem_q  <= sq_full;
      srem_q <= '0;
      root_q <= '0;
      it_q   <= '0;
    end
    if (state_q == StSqrt) begin
      rem_q <= rem_q << 2;
      it_q  <= it_q + ItW'(1);
      if (!s_try[2*RootW+1]) begin
        srem_q <= s_try;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        srem_q <= s_cand;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (state_q == StFtRd) last_q <= (ridx_q + IdxW'(1) >= total);
    if (state_q == StFtSub) begin
      drange_q <= max_q - min_q;
      dvd_q    <= ({8'd0, dcl} << 8) - {8'd0, dcl};
      drem_q   <= '0;
      quo_q    <= '0;
      dit_q    <= '0;
    end
    if (state_q == StDiv) begin
      dit_q <= dit_q + 4'd1;
      if (dit_q == 4'd0) begin
        // first 15 dividend bits never reach the range's size: preload them
        drem_q <= {1'b0, dvd_q[MagW+7:8]};
        dvd_q  <= dvd_q << MagW;
      end else begin
        dvd_q <= dvd_q << 1;
        if (!dtry[MagW]) begin
          drem_q <= dtry;
          quo_q  <= {quo_q[6:0], 1'b1};
        end else begin
          drem_q <= {drem_q[MagW-1:0], dvd_q[MagW+7]};
          quo_q  <= {quo_q[6:0], 1'b0};
        end
      end
    end
    if (state_q == StOut) begin
      if (phase_q == PhRead) begin
        out_stat_q <= 1'b0;
        out_last_q <= last_q;
        out_pix_q  <= (max_q > min_q) ? quo_q : 8'd0;
      end else begin
        out_stat_q <= 1'b1;
        out_last_q <= 1'b0;
        out_pix_q  <= 8'd0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tlast_o  = out_last_q;
endmodule

@@ sv/smn_ram.sv @@
module smn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/smn_checker.sv @@
`include "sobel_magnitude_minmax_normalize_defines.svh"
module smn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid_i,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic m_axis_tuser_o,
  input logic m_axis_tlast_o,
  input logic [7:0] m_axis_tdata_o
);
  `SMN_ASSERT_IMP(a_not_ready_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 8'd0 && !m_axis_tlast_o)
  `SMN_ASSERT_IMP(a_no_take_while_out, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)
  `SMN_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
endmodule

bind sobel_magnitude_minmax_normalize smn_checker u_smn_checker (.*);

@@ test/sobel_magnitude_minmax_normalize_test.sv @@
module sobel_magnitude_minmax_normalize_test;
  import smn_pkg::*;

  localparam int unsigned LineW   = 2 * DefMaxWidth;
  localparam int unsigned MagCnt  = DefMaxWidth * DefMaxHeight;
  localparam int unsigned TimeoutCycles = 3000000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       not_ready;
  } norm_px_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = RegWidth;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = CmdLoad;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [7:0]          m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  sobel_magnitude_minmax_normalize uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always #5 clk_i = ~clk_i;

  // stimulus and expectations
  pixel_cmd_t pending_px[$];
  norm_px_t   expected_px[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_at = 0;

  // predictor state: a mirror of the edge pipeline and the frame buffer
  logic [9:0]  width_reg = 10'd275;
  logic [8:0]  height_reg = 9'd183;
  logic [7:0]  line_buf[LineW];
  logic [7:0]  win[6];
  logic [14:0] mag_buf[MagCnt];
  logic [14:0] mag_lo, mag_hi;
  int unsigned col_pos, row_pos, rd_pos;
  logic        in_readout;

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > DefMaxWidth) return DefMaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > DefMaxHeight) return DefMaxHeight;
    return height_reg;
  endfunction

  function automatic logic [31:0] root_of(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic void restart_frame();
    foreach (win[k]) win[k] = '0;
    mag_lo = '1;
    mag_hi = '0;
    col_pos = 0;
    row_pos = 0;
    rd_pos = 0;
    in_readout = 1'b0;
  endfunction

  function automatic void shift_in_pixel(input logic [7:0] pix);
    int unsigned w, top, mid, idx;
    int a[3][3];
    int gx, gy;
    logic [63:0] sq;
    logic [31:0] m;
    logic [14:0] mag;
    w = eff_width();
    top = (row_pos % 2) * DefMaxWidth + (col_pos < DefMaxWidth ? col_pos : 0);
    mid = ((row_pos + 1) % 2) * DefMaxWidth + (col_pos < DefMaxWidth ? col_pos : 0);
    for (int k = 0; k < 3; k++) begin
      a[k][0] = win[k];
      a[k][1] = win[3 + k];
    end
    a[0][2] = line_buf[top];
    a[1][2] = line_buf[mid];
    a[2][2] = pix;
    for (int k = 0; k < 3; k++) begin
      win[k] = win[3 + k];
      win[3 + k] = a[k][2][7:0];
    end
    line_buf[top] = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (a[0][2] + 2 * a[1][2] + a[2][2]) - (a[0][0] + 2 * a[1][0] + a[2][0]);
      gy = (a[0][0] + 2 * a[0][1] + a[0][2]) - (a[2][0] + 2 * a[2][1] + a[2][2]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      sq = (64'(gx) * 64'(gx) + 64'(gy) * 64'(gy)) << (2 * DefMagFracBits);
      m = root_of(sq);
      mag = (m > 32'h7FFF) ? 15'h7FFF : m[14:0];
      idx = (row_pos - 2) * (w - 2) + (col_pos - 2);
      if (idx < MagCnt) mag_buf[idx] = mag;
      if (mag < mag_lo) mag_lo = mag;
      if (mag > mag_hi) mag_hi = mag;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= eff_height()) begin
        row_pos = 0;
        rd_pos = 0;
        in_readout = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // works out what one accepted transaction leaves on the output, if anything
  function automatic void sobel_step(input pixel_cmd_t it);
    norm_px_t r;
    int unsigned total, range_v, diff;
    logic [14:0] mag;
    if (it.cmd == CmdLoad) begin
      if (!in_readout) shift_in_pixel(it.pixel);
      return;
    end
    r = '0;
    if (!in_readout) begin
      r.not_ready = 1'b1;
      expected_px.push_back(r);
      return;
    end
    total = (eff_width() - 2) * (eff_height() - 2);
    mag = (rd_pos < MagCnt) ? mag_buf[rd_pos] : '0;
    if (mag_hi > mag_lo) begin
      range_v = mag_hi - mag_lo;
      diff = (mag > mag_lo) ? mag - mag_lo : 0;
      if (diff > range_v) diff = range_v;
      r.value = 8'((255 * diff) / range_v);
    end
    r.last = (rd_pos + 1 >= total);
    expected_px.push_back(r);
    if (r.last) restart_frame();
    else rd_pos++;
  endfunction

  // input driver: offers queued transactions, predicts on acceptance
  pixel_cmd_t offered;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) sobel_step(offered);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_px.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= offered.cmd;
          s_axis_tdata_i  <= offered.pixel;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each transaction against the oldest expectation
  always @(posedge clk_i) begin
    norm_px_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_px.size() == 0) begin
          $error("unexpected output transaction: out_pixel %0d", m_axis_tdata_o);
          mismatches++;
        end else begin
          want = expected_px.pop_front();
          if (m_axis_tdata_o !== want.value) begin
            $error("out_pixel expected %0d actual %0d", want.value, m_axis_tdata_o);
            mismatches++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last_pixel expected %0d actual %0d", want.last, m_axis_tlast_o);
            mismatches++;
          end
          if (m_axis_tuser_o !== want.not_ready) begin
            $error("status expected %0d actual %0d", want.not_ready, m_axis_tuser_o);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off to fill the block up
  int unsigned hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_at != 0 && cycle_count == hold_at) begin
      hold_left <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TimeoutCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender drains, then the block gets time to finish a load with no result
  task automatic wait_idle();
    while (pending_px.size() > 0 || s_axis_tvalid_i || expected_px.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegWidth) width_reg = val[9:0];
    else height_reg = val[8:0];
  endtask

  task automatic set_size(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    wait_idle();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] pix);
    pixel_cmd_t it;
    it.cmd = cmd;
    it.pixel = pix;
    pending_px.push_back(it);
  endtask

  // one frame of random content; noise adds early fetches and late loads
  task automatic push_frame(input bit noisy, input bit long_hold, inout int unsigned budget);
    int unsigned n_in, n_out;
    n_in = eff_width() * eff_height();
    n_out = (eff_width() - 2) * (eff_height() - 2);
    for (int unsigned i = 0; i < n_in; i++) begin
      if (noisy && $urandom_range(19) == 0) push_item(CmdFetch, 8'($urandom));
      push_item(CmdLoad, 8'($urandom));
    end
    if (long_hold) begin
      while (pending_px.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
      hold_at = cycle_count + 5;
    end
    for (int unsigned i = 0; i < n_out; i++) begin
      if (noisy && $urandom_range(9) == 0) push_item(CmdLoad, 8'($urandom));
      push_item(CmdFetch, 8'($urandom));
    end
    budget = (budget > n_in + n_out) ? budget - n_in - n_out : 0;
  endtask

  initial begin
    int unsigned budget;
    restart_frame();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fetch before any frame, then two tiny frames
    push_item(CmdFetch, 8'h00);
    set_size(10'd3, 10'd3);
    // step edge with the pixel extremes
    for (int i = 0; i < 9; i++) push_item(CmdLoad, (i % 3 == 2) ? 8'hFF : 8'h00);
    push_item(CmdLoad, 8'hAA);   // ignored during readout
    push_item(CmdFetch, 8'h00);
    // flat frame: min equals max
    for (int i = 0; i < 9; i++) push_item(CmdLoad, 8'd200);
    push_item(CmdFetch, 8'hFF);
    push_item(CmdFetch, 8'h00);  // not ready again after restart

    for (int mode = 0; mode < 4; mode++) begin
      wait_idle();
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      budget = 130;
      if (mode == 0) begin
        set_size(10'd0, 10'd0);      // clamps to the smallest frame
        push_frame(1'b0, 1'b0, budget);
        set_size(10'd6, 10'd5);
        push_frame(1'b0, 1'b1, budget);
      end
      if (mode == 2) begin
        set_size(10'd2, 10'd30);     // narrowest frame, clamped width
        push_frame(1'b1, 1'b0, budget);
      end
      budget = 130;
      while (budget > 0) begin
        set_size(10'($urandom_range(0, 12)), 10'($urandom_range(0, 9)));
        push_frame($urandom_range(3) == 0, 1'b0, budget);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/smn_pkg.sv
sv/smn_ram.sv
sv/sobel_magnitude_minmax_normalize.sv
sv/smn_checker.sv
test/sobel_magnitude_minmax_normalize_test.sv
